// ----- rtl/core/host_link_supervisor_deframer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the host link supervisor / deframer
// Short concurrent checks on a clock with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef HOST_LINK_SUPERVISOR_DEFRAMER_UNIT_ASSERT_SVH
`define HOST_LINK_SUPERVISOR_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define HLSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hlsd: same-cycle check failed");

// next-cycle implication
`define HLSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hlsd: next-cycle check failed");

`endif

// ----- rtl/core/hlsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsd_pkg
// Shared types and constants of the host link supervisor / deframer.
// ----------------------------------------------------------------------------
package hlsd_pkg;

   localparam int MAX_FRAME  = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] RETRY_RESET = 32'd1000;
   localparam logic [31:0] STALE_RESET = 32'd10000;

   localparam logic [7:0] CH_START = 8'h40;  // '@'
   localparam logic [7:0] CH_END   = 8'h2F;  // '/'

   typedef enum logic [1:0] {
      ACT_POLL     = 2'd0,
      ACT_BYTE     = 2'd1,
      ACT_ANNOUNCE = 2'd2,
      ACT_OUTCOME  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_CLOSE   = 2'd0,
      KIND_CONNECT = 2'd1,
      KIND_ONLINE  = 2'd2,
      KIND_BYTE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FALLBACK_IP    = 2'd0,
      CSR_FALLBACK_VALID = 2'd1,
      CSR_RETRY_MS       = 2'd2,
      CSR_STALE_MS       = 2'd3
   } csr_reg_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic exec;       // evaluate and commit the request
      logic emit;       // load a pending control result into the output reg
      logic slot;       // which pending result
      logic rd;         // frame buffer read
      logic emit_byte;  // load the read payload byte into the output reg
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       out_free;
      logic [1:0] plan_cnt;
      logic       plan_replay;
      logic [1:0] pend_cnt;
      logic       rep_last;
   } dp_status_type;

endpackage

// ----- rtl/core/hlsd_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsd channel interfaces
// Valid/ready request and response channels of the supervisor.
// ----------------------------------------------------------------------------
interface hlsd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] now_ms;
   logic        wifi_up;
   logic        link_up;
   logic [7:0]  rx_byte;
   logic [31:0] announced_ip;

   modport source (output valid, action, now_ms, wifi_up, link_up, rx_byte, announced_ip,
                   input ready);
   modport sink   (input valid, action, now_ms, wifi_up, link_up, rx_byte, announced_ip,
                   output ready);
endinterface

interface hlsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] host_ip;
   logic [7:0]  data_byte;
   logic        last;

   modport source (output valid, kind, host_ip, data_byte, last, input ready);
   modport sink   (input valid, kind, host_ip, data_byte, last, output ready);
endinterface

// ----- rtl/core/hlsd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsd_datapath
// Config registers, link/target state, frame buffer and output register.
// ----------------------------------------------------------------------------
module hlsd_datapath #(
   parameter int MaxFrame = hlsd_pkg::MAX_FRAME
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hlsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hlsd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [1:0]                          req_action,
   input  logic [31:0]                         req_now_ms,
   input  logic                                req_wifi_up,
   input  logic                                req_link_up,
   input  logic [7:0]                          req_rx_byte,
   input  logic [31:0]                         req_announced_ip,
   input  hlsd_pkg::ctrl_cmd_type              cmd,
   output hlsd_pkg::dp_status_type             status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_kind,
   output logic [31:0]                         rsp_host_ip,
   output logic [7:0]                          rsp_data_byte,
   output logic                                rsp_last
);
   import hlsd_pkg::*;

   localparam int LenW = $clog2(MaxFrame + 1);
   localparam int IdxW = (MaxFrame > 1) ? $clog2(MaxFrame) : 1;

   // configuration
   logic [31:0] fb_ip_ff, retry_ff, stale_ff;
   logic        fb_valid_ff;

   // latched request
   action_type  act_ff;
   logic [31:0] now_ff, ann_ff;
   logic        wifi_ff, link_ff;
   logic [7:0]  byte_ff;

   // supervisor state
   logic [31:0] tgt_ip_ff, tgt_ip_in;
   logic        tif_ff, tif_in;
   logic        ann_seen_ff, ann_seen_in;
   logic [31:0] last_ann_ff, last_ann_in;
   logic [31:0] last_try_ff, last_try_in;
   logic        first_ff, first_in;
   logic        online_ff, online_in;
   logic        in_frame_ff, in_frame_in;
   logic [LenW-1:0] len_ff, len_in;

   // pending control results
   logic [1:0]  pcnt_ff, pcnt_in;
   kind_type    pk0_ff, pk0_in, pk1_ff, pk1_in;
   logic [31:0] pip_ff, pip_in;

   // frame buffer and replay
   logic [7:0]      frame_mem [MaxFrame];
   logic [7:0]      rd_data_ff;
   logic [LenW-1:0] rep_len_ff, rep_idx_ff;
   logic            mem_we, replay;

   // output register
   logic        out_valid_ff;
   kind_type    out_kind_ff;
   logic [31:0] out_ip_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   logic [31:0] cur_tgt, tgt_after, ann_age, try_age;
   logic        stale, close_a, link_e, wo_e, rep_last, out_free;
   kind_type    emit_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ip_ff    <= '0;
         fb_valid_ff <= 1'b0;
         retry_ff    <= RETRY_RESET;
         stale_ff    <= STALE_RESET;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_FALLBACK_IP:    fb_ip_ff    <= csr_wdata[31:0];
            CSR_FALLBACK_VALID: fb_valid_ff <= csr_wdata[0];
            CSR_RETRY_MS:       retry_ff    <= csr_wdata[31:0];
            CSR_STALE_MS:       stale_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= action_type'(req_action);
         now_ff  <= req_now_ms;
         wifi_ff <= req_wifi_up;
         link_ff <= req_link_up;
         byte_ff <= req_rx_byte;
         ann_ff  <= req_announced_ip;
      end
   end

   assign cur_tgt   = tif_ff ? fb_ip_ff : tgt_ip_ff;
   assign ann_age   = now_ff - last_ann_ff;
   assign try_age   = now_ff - last_try_ff;
   assign stale     = ann_seen_ff && (ann_age > stale_ff);
   assign tgt_after = stale ? fb_ip_ff : cur_tgt;
   assign close_a   = stale && (cur_tgt != fb_ip_ff) && link_ff;
   assign link_e    = link_ff && !close_a;
   assign wo_e      = online_ff && !close_a;

   // request evaluation
   always_comb begin
      tgt_ip_in   = tgt_ip_ff;
      tif_in      = tif_ff;
      ann_seen_in = ann_seen_ff;
      last_ann_in = last_ann_ff;
      last_try_in = last_try_ff;
      first_in    = first_ff;
      online_in   = online_ff;
      in_frame_in = in_frame_ff;
      len_in      = len_ff;
      pcnt_in     = 2'd0;
      pk0_in      = KIND_CLOSE;
      pk1_in      = KIND_CLOSE;
      pip_in      = tgt_after;
      mem_we      = 1'b0;
      replay      = 1'b0;
      if (fb_valid_ff) begin
         case (act_ff)
            ACT_POLL: begin
               if (!wifi_ff) begin
                  if (link_ff) begin
                     pcnt_in = 2'd1;
                  end
                  online_in   = 1'b0;
                  in_frame_in = 1'b0;
                  len_in      = '0;
               end else begin
                  if (stale) begin
                     ann_seen_in = 1'b0;
                     if (cur_tgt != fb_ip_ff) begin
                        tif_in = 1'b1;
                     end
                  end
                  if (close_a) begin
                     pcnt_in     = 2'd1;
                     online_in   = 1'b0;
                     in_frame_in = 1'b0;
                     len_in      = '0;
                  end
                  if (!link_e) begin
                     if (wo_e) begin
                        // link dropped after being online: close, restart wait
                        pcnt_in     = 2'd1;
                        online_in   = 1'b0;
                        in_frame_in = 1'b0;
                        len_in      = '0;
                        last_try_in = now_ff;
                        first_in    = 1'b0;
                     end else if (first_ff || (try_age >= retry_ff)) begin
                        last_try_in = now_ff;
                        first_in    = 1'b0;
                        if (close_a) begin
                           pk1_in  = KIND_CONNECT;
                           pcnt_in = 2'd2;
                        end else begin
                           pk0_in  = KIND_CONNECT;
                           pcnt_in = 2'd1;
                        end
                     end
                  end else begin
                     online_in = 1'b1;
                  end
               end
            end
            ACT_BYTE: begin
               if (online_ff) begin
                  if (byte_ff == CH_START) begin
                     len_in      = '0;
                     in_frame_in = 1'b1;
                  end else if (byte_ff == CH_END) begin
                     if (in_frame_ff) begin
                        in_frame_in = 1'b0;
                        replay      = (len_ff != '0);
                        len_in      = '0;
                     end
                  end else if (in_frame_ff) begin
                     if (len_ff < LenW'(MaxFrame)) begin
                        mem_we = 1'b1;
                        len_in = len_ff + LenW'(1);
                     end else begin
                        // overlong: drop and wait for the next start
                        in_frame_in = 1'b0;
                        len_in      = '0;
                     end
                  end
               end
            end
            ACT_ANNOUNCE: begin
               ann_seen_in = 1'b1;
               last_ann_in = now_ff;
               if (ann_ff != cur_tgt) begin
                  tgt_ip_in = ann_ff;
                  tif_in    = 1'b0;
                  if (link_ff) begin
                     pcnt_in     = 2'd1;
                     online_in   = 1'b0;
                     in_frame_in = 1'b0;
                     len_in      = '0;
                  end
               end
            end
            default: begin  // connect outcome
               if (link_ff) begin
                  in_frame_in = 1'b0;
                  len_in      = '0;
                  pk0_in      = KIND_ONLINE;
                  pcnt_in     = 2'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ip_ff   <= '0;
         tif_ff      <= 1'b1;
         ann_seen_ff <= 1'b0;
         last_ann_ff <= '0;
         last_try_ff <= '0;
         first_ff    <= 1'b1;
         online_ff   <= 1'b0;
         in_frame_ff <= 1'b0;
         len_ff      <= '0;
         pcnt_ff     <= 2'd0;
      end else if (cmd.exec) begin
         tgt_ip_ff   <= tgt_ip_in;
         tif_ff      <= tif_in;
         ann_seen_ff <= ann_seen_in;
         last_ann_ff <= last_ann_in;
         last_try_ff <= last_try_in;
         first_ff    <= first_in;
         online_ff   <= online_in;
         in_frame_ff <= in_frame_in;
         len_ff      <= len_in;
         pcnt_ff     <= pcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pk0_ff <= pk0_in;
         pk1_ff <= pk1_in;
         pip_ff <= pip_in;
         if (replay) begin
            rep_len_ff <= len_ff;
            rep_idx_ff <= '0;
         end
      end else if (cmd.emit_byte) begin
         rep_idx_ff <= rep_idx_ff + LenW'(1);
      end
   end

   // frame buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.exec && mem_we) begin
         frame_mem[len_ff[IdxW-1:0]] <= byte_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= frame_mem[rep_idx_ff[IdxW-1:0]];
      end
   end

   assign rep_last  = (rep_idx_ff + LenW'(1)) == rep_len_ff;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit_kind = cmd.slot ? pk1_ff : pk0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff <= emit_kind;
         out_ip_ff   <= (emit_kind == KIND_CONNECT) ? pip_ff : '0;
         out_byte_ff <= '0;
         out_last_ff <= 1'b0;
      end else if (cmd.emit_byte) begin
         out_kind_ff <= KIND_BYTE;
         out_ip_ff   <= '0;
         out_byte_ff <= rd_data_ff;
         out_last_ff <= rep_last;
      end
   end

   assign status.out_free    = out_free;
   assign status.plan_cnt    = pcnt_in;
   assign status.plan_replay = replay;
   assign status.pend_cnt    = pcnt_ff;
   assign status.rep_last    = rep_last;

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_host_ip   = out_ip_ff;
   assign rsp_data_byte = out_byte_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ----- rtl/core/hlsd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsd_ctrl
// Sequencer: accept, evaluate, emit control results, replay payload.
// ----------------------------------------------------------------------------
module hlsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  hlsd_pkg::dp_status_type status,
   output hlsd_pkg::ctrl_cmd_type  cmd
);
   import hlsd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT,
      ST_READ,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      slot_ff, slot_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      slot_in   = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.plan_cnt != 2'd0) begin
               slot_in  = 1'b0;
               state_in = ST_EMIT;
            end else if (status.plan_replay) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            cmd.slot = slot_ff;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (({1'b0, slot_ff} + 2'd1) == status.pend_cnt) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.emit_byte = 1'b1;
               state_in      = status.rep_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

// ----- rtl/core/host_link_supervisor_deframer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_link_supervisor_deframer_unit
// Host connection supervisor with '@payload/' command deframer.
// ----------------------------------------------------------------------------
// Takes one request transaction at a time: polls (time, wifi, link status),
// received bytes, host announcements and connect outcomes. A request that
// yields no result is accepted, then evaluated. Close/connect/online results
// follow, each loaded into the output register once it is free, so a poll
// that closes and reconnects emits two. A completed command frame of N
// payload bytes is replayed from the frame buffer, each byte by a buffer read,
// then a load into the output register once free, paced by the single read
// port of the buffer. The next request is taken while the final result still
// waits in the output register. Nothing happens while fallback_valid is clear;
// configuration is to be written only while idle, which the block itself does
// not enforce. Time comparisons wrap modulo 2^32. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "host_link_supervisor_deframer_unit_assert.svh"

module host_link_supervisor_deframer_unit #(
   parameter int MaxFrame = hlsd_pkg::MAX_FRAME   // 1 .. 64 payload bytes
) (
   input  logic                            clock,
   input  logic                            reset,
   hlsd_req_if.sink                        req_chan,
   hlsd_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [hlsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hlsd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hlsd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   // sequencer: one request in flight, then its results
   hlsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state, frame buffer, output register
   hlsd_datapath #(
      .MaxFrame (MaxFrame)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action       (req_chan.action),
      .req_now_ms       (req_chan.now_ms),
      .req_wifi_up      (req_chan.wifi_up),
      .req_link_up      (req_chan.link_up),
      .req_rx_byte      (req_chan.rx_byte),
      .req_announced_ip (req_chan.announced_ip),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_kind         (rsp_chan.kind),
      .rsp_host_ip      (rsp_chan.host_ip),
      .rsp_data_byte    (rsp_chan.data_byte),
      .rsp_last         (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

   // a load never overwrites a result still waiting downstream
   `HLSD_ASSERT_NOW(a_load_needs_room, clock, reset, (cmd.emit || cmd.emit_byte), status.out_free)
   // an accepted transaction is evaluated in the next cycle
   `HLSD_ASSERT_NEXT(a_accept_then_exec, clock, reset, (req_chan.valid && req_ready), cmd.exec)
   // each buffer read is consumed before the next one is issued
   `HLSD_ASSERT_NEXT(a_read_spacing, clock, reset, cmd.rd, !cmd.rd)
   // payload replay never comes with pending control results
   `HLSD_ASSERT_NOW(a_replay_alone, clock, reset, status.plan_replay, status.plan_cnt == 2'd0)

endmodule
